// File: rtl/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg: shared definitions of the line segment clipper
// Widths, fixed point formats, register codes and stage structs.
// ----------------------------------------------------------------------------
package lsrc_pkg;

    localparam int COORD_W    = 24;
    localparam int COORD_FRAC = 4;
    localparam int FRAC       = 16;
    localparam int CFG_W      = 12;
    localparam int EDGE_W     = CFG_W + COORD_FRAC;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = COORD_W + 1;
    localparam int QUO_W      = FRAC + 1;
    localparam int T_W        = FRAC + 2;
    localparam int U_W        = FRAC + 1;
    localparam int DIV_LAT    = FRAC + 1;
    localparam int NTEST      = 4;

    localparam logic [T_W-1:0] PARAM_ONE = T_W'(1) << FRAC;
    localparam logic [T_W-1:0] PARAM_SAT = PARAM_ONE + T_W'(1);

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

    // Per boundary test: parallel to the edge, entering edge, negative quotient.
    typedef struct packed {
        logic skip;
        logic enter;
        logic neg;
    } test_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        test_t [NTEST-1:0]         tst;
        logic                      par_rej;
    } side_t;

endpackage

// File: rtl/lsrc_setup.sv
// ----------------------------------------------------------------------------
// lsrc_setup: segment setup
// Two stages: deltas and edge distances, then magnitudes and test flags.
// ----------------------------------------------------------------------------
module lsrc_setup
    import lsrc_pkg::*;
(
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [COORD_W-1:0]       start_x,
    input  logic signed [COORD_W-1:0]       start_y,
    input  logic signed [COORD_W-1:0]       end_x,
    input  logic signed [COORD_W-1:0]       end_y,
    input  logic [EDGE_W-1:0]               xmax,
    input  logic [EDGE_W-1:0]               ymax,
    output side_t                           side,
    output logic [NTEST-1:0][MAG_W-1:0]     num,
    output logic [NTEST-1:0][MAG_W-1:0]     den
);

    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [DIFF_W-1:0]  q_reg [NTEST];
    logic signed [DIFF_W-1:0]  x0_ext, y0_ext, x1_ext, y1_ext;

    side_t                       side_next, side_reg;
    logic [NTEST-1:0][MAG_W-1:0] num_next, num_reg, den_next, den_reg;
    logic [MAG_W-1:0]            mag_dx, mag_dy;
    logic                        dx_neg, dy_neg, dx_zero, dy_zero;
    logic [NTEST-1:0]            p_neg, p_zero;

    assign x0_ext = {start_x[COORD_W-1], start_x};
    assign y0_ext = {start_y[COORD_W-1], start_y};
    assign x1_ext = {end_x[COORD_W-1], end_x};
    assign y1_ext = {end_y[COORD_W-1], end_y};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= start_x;
            y0_reg   <= start_y;
            x1_reg   <= end_x;
            y1_reg   <= end_y;
            dx_reg   <= x1_ext - x0_ext;
            dy_reg   <= y1_ext - y0_ext;
            q_reg[0] <= x0_ext;
            q_reg[1] <= $signed(DIFF_W'(xmax)) - x0_ext;
            q_reg[2] <= y0_ext;
            q_reg[3] <= $signed(DIFF_W'(ymax)) - y0_ext;
        end
    end

    always_comb
    begin
        dx_neg  = dx_reg[DIFF_W-1];
        dy_neg  = dy_reg[DIFF_W-1];
        dx_zero = (dx_reg == '0);
        dy_zero = (dy_reg == '0);
        mag_dx  = dx_neg ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
        mag_dy  = dy_neg ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);

        // Left and top use -delta, right and bottom use +delta.
        p_zero = {dy_zero, dy_zero, dx_zero, dx_zero};
        p_neg  = {dy_neg, !dy_neg && !dy_zero, dx_neg, !dx_neg && !dx_zero};

        side_next.x0      = x0_reg;
        side_next.y0      = y0_reg;
        side_next.x1      = x1_reg;
        side_next.y1      = y1_reg;
        side_next.dx      = dx_reg;
        side_next.dy      = dy_reg;
        side_next.par_rej = 1'b0;
        for (int i = 0; i < NTEST; i++)
        begin
            side_next.tst[i].skip  = p_zero[i];
            side_next.tst[i].enter = p_neg[i];
            side_next.tst[i].neg   = (q_reg[i] != '0) && (q_reg[i][DIFF_W-1] != p_neg[i]);
            num_next[i] = q_reg[i][DIFF_W-1] ? MAG_W'(-q_reg[i]) : MAG_W'(q_reg[i]);
            den_next[i] = (i < 2) ? mag_dx : mag_dy;
            if (p_zero[i] && q_reg[i][DIFF_W-1])
            begin
                side_next.par_rej = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign side = side_reg;
    assign num  = num_reg;
    assign den  = den_reg;

endmodule

// File: rtl/lsrc_div.sv
// ----------------------------------------------------------------------------
// lsrc_div: pipelined parameter divider
// Restoring division, one quotient bit per stage, with a saturation flag.
// ----------------------------------------------------------------------------
module lsrc_div
    import lsrc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MAG_W-1:0]  num,
    input  logic [MAG_W-1:0]  den,
    output logic [QUO_W-1:0]  quo,
    output logic              sat
);

    logic [MAG_W-1:0] rem_reg [DIV_LAT];
    logic [MAG_W-1:0] den_reg [DIV_LAT];
    logic [QUO_W-1:0] quo_reg [DIV_LAT];
    logic             sat_reg [DIV_LAT];
    logic [MAG_W-1:0] rem_next [DIV_LAT];
    logic [MAG_W-1:0] den_next [DIV_LAT];
    logic [QUO_W-1:0] quo_next [DIV_LAT];
    logic             sat_next [DIV_LAT];
    logic [MAG_W:0]   shf [DIV_LAT];
    logic [MAG_W:0]   sub [DIV_LAT];
    logic             ge  [DIV_LAT];

    always_comb
    begin
        // The first stage produces the unit bit without a shift; a quotient
        // of two or more saturates.
        shf[0]      = {1'b0, num};
        sub[0]      = {1'b0, num} - {1'b0, den};
        ge[0]       = (num >= den);
        sat_next[0] = ({1'b0, num} >= {den, 1'b0});
        rem_next[0] = ge[0] ? sub[0][MAG_W-1:0] : num;
        quo_next[0] = QUO_W'(ge[0]);
        den_next[0] = den;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            shf[k]      = {rem_reg[k-1], 1'b0};
            sub[k]      = shf[k] - {1'b0, den_reg[k-1]};
            ge[k]       = (shf[k] >= {1'b0, den_reg[k-1]});
            rem_next[k] = ge[k] ? sub[k][MAG_W-1:0] : shf[k][MAG_W-1:0];
            quo_next[k] = {quo_reg[k-1][QUO_W-2:0], ge[k]};
            sat_next[k] = sat_reg[k-1];
            den_next[k] = den_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
                sat_reg[k] <= sat_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];
    assign sat = sat_reg[DIV_LAT-1];

endmodule

// File: rtl/lsrc_lerp.sv
// ----------------------------------------------------------------------------
// lsrc_lerp: endpoint interpolation
// Registers u times |delta|, then adds it to or subtracts it from the start.
// ----------------------------------------------------------------------------
module lsrc_lerp
    import lsrc_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [COORD_W-1:0]  base,
    input  logic signed [DIFF_W-1:0]   d,
    input  logic [U_W-1:0]             u,
    output logic [COORD_W-1:0]         value
);

    logic [MAG_W-1:0]       mag_d;
    logic [U_W+MAG_W-1:0]   prod_reg;
    logic [COORD_W-1:0]     base_reg;
    logic                   neg_reg;
    logic [COORD_W-1:0]     step;

    assign mag_d = d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (U_W+MAG_W)'(u) * (U_W+MAG_W)'(mag_d);
            base_reg <= base;
            neg_reg  <= d[DIFF_W-1];
        end
    end

    // The product is truncated toward zero in magnitude; the sum stays
    // between the endpoints, so the low bits are the whole answer.
    assign step  = prod_reg[FRAC +: COORD_W];
    assign value = neg_reg ? base_reg - step : base_reg + step;

endmodule

// File: rtl/line_segment_rect_clipper_unit.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper_unit: Liang-Barsky segment clipper
// Clips one segment per unstalled cycle to the window [0,width] x [0,height].
// ----------------------------------------------------------------------------
// Usage:
// Segments arrive on the input channel (in_valid / in_stall) as two endpoints
// in signed fixed point with four fraction bits. Each transfer yields exactly
// one result transfer on the output channel (out_valid / out_stall): the
// visible flag and the clipped endpoints, or the original endpoints when the
// segment is rejected.
// A segment passes from input transfer to output valid through two setup
// stages, seventeen divider stages (one quotient bit each), two decision
// stages, one multiply stage and the output register. Throughput is one
// segment per unstalled cycle; the divider pipeline sets the depth.
// When the receiver stalls a valid output, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads a 640 by 480 window. The window
// registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module line_segment_rect_clipper_unit
    import lsrc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [COORD_W-1:0]  start_x,
    input  logic signed [COORD_W-1:0]  start_y,
    input  logic signed [COORD_W-1:0]  end_x,
    input  logic signed [COORD_W-1:0]  end_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       visible,
    output logic signed [COORD_W-1:0]  clipped_start_x,
    output logic signed [COORD_W-1:0]  clipped_start_y,
    output logic signed [COORD_W-1:0]  clipped_end_x,
    output logic signed [COORD_W-1:0]  clipped_end_y
);

    localparam int LAT = DIV_LAT + 6;

    // Window registers.
    logic [CFG_W-1:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // The pipeline advances as one unit unless a finished result is held.
    logic en;
    logic vld_reg [LAT];

    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Setup: deltas, edge distances and per-test flags.
    side_t                       side_s2;
    logic [NTEST-1:0][MAG_W-1:0] num_s2, den_s2;

    lsrc_setup u_setup (
        .clk     (clk),
        .en      (en),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .xmax    ({width_reg, COORD_FRAC'(0)}),
        .ymax    ({height_reg, COORD_FRAC'(0)}),
        .side    (side_s2),
        .num     (num_s2),
        .den     (den_s2)
    );

    // Four dividers in parallel, one per boundary, with the segment data
    // carried alongside them.
    logic [NTEST-1:0][QUO_W-1:0] quo;
    logic [NTEST-1:0]            sat;
    side_t                       side_dly_reg [DIV_LAT];

    for (genvar i = 0; i < NTEST; i++)
    begin : g_div
        lsrc_div u_div (
            .clk (clk),
            .en  (en),
            .num (num_s2[i]),
            .den (den_s2[i]),
            .quo (quo[i]),
            .sat (sat[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side_s2;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // First decision stage: saturate each quotient and turn it into an
    // entering or leaving candidate. A leaving test with a negative quotient
    // rejects outright; a negative entering quotient changes nothing.
    side_t                      side_d1_reg;
    logic [NTEST-1:0][T_W-1:0]  enc_next, enc_reg, lvc_next, lvc_reg;
    logic                       rej_next, rej_reg;
    logic [T_W-1:0]             t_val [NTEST];
    side_t                      side_dv;

    assign side_dv = side_dly_reg[DIV_LAT-1];

    always_comb
    begin
        rej_next = side_dv.par_rej;
        for (int i = 0; i < NTEST; i++)
        begin
            if (sat[i] || (T_W'(quo[i]) > PARAM_SAT))
            begin
                t_val[i] = PARAM_SAT;
            end
            else
            begin
                t_val[i] = T_W'(quo[i]);
            end
            enc_next[i] = '0;
            lvc_next[i] = PARAM_ONE;
            if (!side_dv.tst[i].skip && !side_dv.tst[i].neg)
            begin
                if (side_dv.tst[i].enter)
                begin
                    enc_next[i] = t_val[i];
                end
                else
                begin
                    lvc_next[i] = t_val[i];
                end
            end
            if (!side_dv.tst[i].skip && !side_dv.tst[i].enter && side_dv.tst[i].neg)
            begin
                rej_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d1_reg <= side_dv;
            enc_reg     <= enc_next;
            lvc_reg     <= lvc_next;
            rej_reg     <= rej_next;
        end
    end

    // Second decision stage: the entering parameter is the largest candidate,
    // leaving the smallest; visible when not rejected and they do not cross.
    side_t          side_d2_reg;
    logic [T_W-1:0] u1_max, u2_min;
    logic [U_W-1:0] u1_reg, u2_reg;
    logic           vis_d2_reg;

    always_comb
    begin
        u1_max = '0;
        u2_min = PARAM_ONE;
        for (int i = 0; i < NTEST; i++)
        begin
            if (enc_reg[i] > u1_max)
            begin
                u1_max = enc_reg[i];
            end
            if (lvc_reg[i] < u2_min)
            begin
                u2_min = lvc_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d2_reg <= side_d1_reg;
            u1_reg      <= u1_max[U_W-1:0];
            u2_reg      <= u2_min[U_W-1:0];
            vis_d2_reg  <= !rej_reg && (u1_max <= u2_min);
        end
    end

    // Interpolation of both clipped endpoints.
    logic [COORD_W-1:0] lx0, ly0, lx1, ly1;
    logic [COORD_W-1:0] ox0_reg, oy0_reg, ox1_reg, oy1_reg;
    logic               vis_l1_reg;

    lsrc_lerp u_lerp_x0 (.clk(clk), .en(en), .base(side_d2_reg.x0), .d(side_d2_reg.dx),
                         .u(u1_reg), .value(lx0));
    lsrc_lerp u_lerp_y0 (.clk(clk), .en(en), .base(side_d2_reg.y0), .d(side_d2_reg.dy),
                         .u(u1_reg), .value(ly0));
    lsrc_lerp u_lerp_x1 (.clk(clk), .en(en), .base(side_d2_reg.x0), .d(side_d2_reg.dx),
                         .u(u2_reg), .value(lx1));
    lsrc_lerp u_lerp_y1 (.clk(clk), .en(en), .base(side_d2_reg.y0), .d(side_d2_reg.dy),
                         .u(u2_reg), .value(ly1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_l1_reg <= vis_d2_reg;
            ox0_reg    <= side_d2_reg.x0;
            oy0_reg    <= side_d2_reg.y0;
            ox1_reg    <= side_d2_reg.x1;
            oy1_reg    <= side_d2_reg.y1;
        end
    end

    // Output register: rejected segments keep their original endpoints.
    logic               vis_out_reg;
    logic [COORD_W-1:0] cx0_reg, cy0_reg, cx1_reg, cy1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_out_reg <= vis_l1_reg;
            cx0_reg     <= vis_l1_reg ? lx0 : ox0_reg;
            cy0_reg     <= vis_l1_reg ? ly0 : oy0_reg;
            cx1_reg     <= vis_l1_reg ? lx1 : ox1_reg;
            cy1_reg     <= vis_l1_reg ? ly1 : oy1_reg;
        end
    end

    assign out_valid       = vld_reg[LAT-1];
    assign visible         = vis_out_reg;
    assign clipped_start_x = $signed(cx0_reg);
    assign clipped_start_y = $signed(cy0_reg);
    assign clipped_end_x   = $signed(cx1_reg);
    assign clipped_end_y   = $signed(cy1_reg);

`ifndef SYNTH
    // The input side stalls exactly when a held result blocks the pipeline.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the held output");

    // A frozen pipeline keeps its result valid into the next cycle.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("held result dropped");

    // A visible segment always has its entering parameter at or below leaving.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DIV_LAT+3] && vis_d2_reg) |-> (u1_reg <= u2_reg))
        else $error("visible segment with crossed parameters");

    // The smallest leaving parameter never exceeds one.
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_LAT+2] |-> (u2_min <= PARAM_ONE))
        else $error("leaving parameter above one");
`endif

endmodule
